@@ rtl/glos_pkg.sv @@
// Shared constants and controller/datapath interface types for the line-of-sight unit.
package glos_pkg;

   localparam int CELL_W          = 12;
   localparam int COLS_CFG_W      = 7;
   localparam int IDX_W           = 17;
   localparam int GRID_CELLS_DEF  = 4096;
   localparam int MAX_COLUMNS_DEF = 64;

   localparam logic [COLS_CFG_W-1:0] COLS_RESET = 7'd64;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic clear;
      logic write;
      logic load;
      logic div_step;
      logic setup;
      logic step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic div_last;
      logic zero_len;
      logic last_point;
      logic out_free;
   } status_type;

endpackage

@@ rtl/glos_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module glos_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/glos_ctrl.sv @@
// Sequencer for clearing, wall writes and line-of-sight queries.
module glos_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic                in_op,
   output logic                in_ready,
   input  glos_pkg::status_type status,
   output glos_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_SETUP = 3'd3;
   localparam logic [2:0] ST_STEP  = 3'd4;
   localparam logic [2:0] ST_DRAIN = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   assign in_ready = (state_ff == ST_IDLE);
   assign accept   = in_valid && in_ready;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (in_op == glos_pkg::OP_WRITE) begin
                  cmd.write = 1'b1;
               end else begin
                  cmd.load = 1'b1;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            // equal endpoints leave no line to walk
            state_in = status.zero_len ? ST_DONE : ST_STEP;
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            if (status.last_point) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the result register can take the transaction
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/glos_dp.sv @@
// Datapath: wall map, column divider, incremental line stepper and result register.
module glos_dp #(
   parameter int GRID_CELLS  = glos_pkg::GRID_CELLS_DEF,
   parameter int MAX_COLUMNS = glos_pkg::MAX_COLUMNS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  glos_pkg::cmd_type                   cmd,
   output glos_pkg::status_type                status,
   input  logic                                csr_write_enable,
   input  logic [glos_pkg::COLS_CFG_W-1:0]     csr_write_data,
   input  logic [glos_pkg::CELL_W-1:0]         write_cell,
   input  logic                                wall_flag,
   input  logic [glos_pkg::CELL_W-1:0]         start_cell,
   input  logic [glos_pkg::CELL_W-1:0]         end_cell,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic                                rsp_visible
);

   localparam int CELL_W = glos_pkg::CELL_W;
   localparam int IDX_W  = glos_pkg::IDX_W;
   localparam int AW     = $clog2(GRID_CELLS);
   localparam int CW     = $clog2(MAX_COLUMNS + 1);
   localparam int CMPW   = (CW > glos_pkg::COLS_CFG_W) ? CW : glos_pkg::COLS_CFG_W;
   localparam int DCW    = $clog2(CELL_W);
   localparam int SW     = CELL_W + 4;

   // one axis of the stepper: r tracks (2*i*d + s) mod 2s, flags mark a unit move
   function automatic logic [SW+1:0] axis_step(input logic signed [SW-1:0] r,
                                                input logic signed [SW-1:0] d2,
                                                input logic signed [SW-1:0] s2);
      logic signed [SW-1:0] t;
      logic signed [SW-1:0] rn;
      logic                 inc;
      logic                 dec;
      t   = r + d2;
      rn  = t;
      inc = 1'b0;
      dec = 1'b0;
      if (!d2[SW-1]) begin
         if (t >= s2) begin
            rn  = t - s2;
            inc = 1'b1;
         end
      end else begin
         if (t[SW-1]) begin
            rn  = t + s2;
            dec = 1'b1;
         end
      end
      return {inc, dec, rn};
   endfunction

   // configuration register
   logic [glos_pkg::COLS_CFG_W-1:0] grid_columns_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_columns_ff <= glos_pkg::COLS_RESET;
      end else if (csr_write_enable) begin
         grid_columns_ff <= csr_write_data;
      end
   end

   logic [CMPW-1:0] cfg_ext;
   logic [CMPW-1:0] cols_sat;

   always_comb begin
      cfg_ext = CMPW'(grid_columns_ff);
      priority if (cfg_ext == '0) begin
         cols_sat = CMPW'(1);
      end else if (cfg_ext > CMPW'(MAX_COLUMNS)) begin
         cols_sat = CMPW'(MAX_COLUMNS);
      end else begin
         cols_sat = cfg_ext;
      end
   end

   // query registers and column divider
   logic [CW-1:0]     cols_ff;
   logic [CELL_W-1:0] start_ff;
   logic [CELL_W-1:0] end_ff;
   logic [CELL_W-1:0] sh_a_ff, sh_b_ff;
   logic [CW-1:0]     rem_a_ff, rem_b_ff;
   logic [DCW-1:0]    dcnt_ff;

   logic [CW:0]       trial_a, trial_b;
   logic              ge_a, ge_b;

   assign trial_a = {rem_a_ff, sh_a_ff[CELL_W-1]};
   assign trial_b = {rem_b_ff, sh_b_ff[CELL_W-1]};
   assign ge_a    = trial_a >= {1'b0, cols_ff};
   assign ge_b    = trial_b >= {1'b0, cols_ff};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cols_ff  <= cols_sat[CW-1:0];
         start_ff <= start_cell;
         end_ff   <= end_cell;
         sh_a_ff  <= start_cell;
         sh_b_ff  <= end_cell;
         rem_a_ff <= '0;
         rem_b_ff <= '0;
         dcnt_ff  <= '0;
      end else if (cmd.div_step) begin
         sh_a_ff  <= {sh_a_ff[CELL_W-2:0], ge_a};
         sh_b_ff  <= {sh_b_ff[CELL_W-2:0], ge_b};
         rem_a_ff <= ge_a ? CW'(trial_a - {1'b0, cols_ff}) : trial_a[CW-1:0];
         rem_b_ff <= ge_b ? CW'(trial_b - {1'b0, cols_ff}) : trial_b[CW-1:0];
         dcnt_ff  <= dcnt_ff + DCW'(1);
      end
   end

   // line setup: remainders are columns, quotients are rows
   logic signed [SW-1:0] dx_s, dy_s, adx, ady;
   logic [CELL_W-1:0]    s_calc;

   always_comb begin
      dx_s   = $signed(SW'(rem_b_ff)) - $signed(SW'(rem_a_ff));
      dy_s   = $signed(SW'(sh_b_ff)) - $signed(SW'(sh_a_ff));
      adx    = dx_s[SW-1] ? -dx_s : dx_s;
      ady    = dy_s[SW-1] ? -dy_s : dy_s;
      s_calc = (ady > adx) ? ady[CELL_W-1:0] : adx[CELL_W-1:0];
   end

   // stepper
   logic [CELL_W-1:0]    s_ff;
   logic [CELL_W-1:0]    i_ff;
   logic signed [SW-1:0] s2_ff;
   logic signed [SW-1:0] dx2_ff, dy2_ff;
   logic signed [SW-1:0] rx_ff, ry_ff;
   logic [IDX_W-1:0]     cell_ff;
   logic [SW+1:0]        stx, sty;
   logic [IDX_W-1:0]     x_term, y_term;

   assign stx = axis_step(rx_ff, dx2_ff, s2_ff);
   assign sty = axis_step(ry_ff, dy2_ff, s2_ff);

   always_comb begin
      priority if (stx[SW+1]) begin
         x_term = IDX_W'(1);
      end else if (stx[SW]) begin
         x_term = -IDX_W'(1);
      end else begin
         x_term = '0;
      end
      priority if (sty[SW+1]) begin
         y_term = IDX_W'(cols_ff);
      end else if (sty[SW]) begin
         y_term = -IDX_W'(cols_ff);
      end else begin
         y_term = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         s_ff    <= s_calc;
         s2_ff   <= $signed(SW'({s_calc, 1'b0}));
         dx2_ff  <= dx_s <<< 1;
         dy2_ff  <= dy_s <<< 1;
         rx_ff   <= $signed(SW'(s_calc));
         ry_ff   <= $signed(SW'(s_calc));
         cell_ff <= IDX_W'(start_ff);
         i_ff    <= '0;
      end else if (cmd.step) begin
         rx_ff   <= stx[SW-1:0];
         ry_ff   <= sty[SW-1:0];
         cell_ff <= cell_ff + x_term + y_term;
         i_ff    <= i_ff + CELL_W'(1);
      end
   end

   // wall map with clearing pass and write port
   logic [AW-1:0]    clr_cnt_ff;
   logic [IDX_W-1:0] wc_ext;
   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   logic             ram_wdata;
   logic             ram_rdata;
   logic             cell_in_map;
   logic             cell_inner;
   logic             chk_ff;
   logic             blocked_ff;

   assign wc_ext = IDX_W'(write_cell);

   always_comb begin
      if (cmd.clear) begin
         ram_we    = 1'b1;
         ram_waddr = clr_cnt_ff;
         ram_wdata = 1'b0;
      end else begin
         // drop writes that fall beyond the map
         ram_we    = cmd.write && (wc_ext < IDX_W'(GRID_CELLS));
         ram_waddr = wc_ext[AW-1:0];
         ram_wdata = wall_flag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear) begin
         clr_cnt_ff <= clr_cnt_ff + AW'(1);
      end
   end

   glos_ram #(
      .WIDTH (1),
      .DEPTH (GRID_CELLS)
   ) u_wall_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (cell_ff[AW-1:0]),
      .rd_data (ram_rdata)
   );

   assign cell_in_map = cell_ff < IDX_W'(GRID_CELLS);
   assign cell_inner  = (cell_ff != IDX_W'(start_ff)) && (cell_ff != IDX_W'(end_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         chk_ff <= 1'b0;
      end else begin
         chk_ff <= cmd.step && cell_in_map && cell_inner;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         blocked_ff <= 1'b0;
      end else if (chk_ff && ram_rdata) begin
         blocked_ff <= 1'b1;
      end
   end

   // result register
   logic rsp_valid_ff;
   logic rsp_visible_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_visible_ff <= !blocked_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_visible = rsp_visible_ff;

   assign status.clear_last = (clr_cnt_ff == AW'(GRID_CELLS - 1));
   assign status.div_last   = (dcnt_ff == DCW'(CELL_W - 1));
   assign status.zero_len   = (s_calc == '0);
   assign status.last_point = (i_ff == s_ff);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

endmodule

@@ rtl/grid_line_of_sight_unit.sv @@
// Top level of the grid line-of-sight unit: controller, datapath and stream ports.
//
// A one-bit wall map of GRID_CELLS cells is held in a RAM. After reset the unit
// clears the map and accepts no transaction until that pass is done (register
// writes are taken at any time). A wall write goes into the map as it is
// accepted. For a query, a bit-serial divider splits both cell indices into
// column and row, a setup step prepares the line, then the stepper visits one
// point per cycle, each a read of the single wall-map port, and a drain step
// finishes the last read before the result is loaded. Equal endpoints skip the
// walk. A finished result sits in an output register, so the next transaction
// is accepted while it waits to be taken; a later result is loaded only once
// that register is free.
module grid_line_of_sight_unit #(
   parameter int GRID_CELLS  = glos_pkg::GRID_CELLS_DEF,
   parameter int MAX_COLUMNS = glos_pkg::MAX_COLUMNS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [glos_pkg::COLS_CFG_W-1:0] csr_write_data,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // write_cell[11:0], wall_flag[12], start_cell[24:13], end_cell[36:25]
   input  logic [39:0]                     req_tdata,
   // operation[0]
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // visible[0]
   output logic [7:0]                      rsp_tdata
);

   glos_pkg::cmd_type    cmd;
   glos_pkg::status_type status;
   logic                 visible;

   glos_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_op    (req_tuser),
      .in_ready (req_tready),
      .status   (status),
      .cmd      (cmd)
   );

   glos_dp #(
      .GRID_CELLS  (GRID_CELLS),
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .write_cell       (req_tdata[11:0]),
      .wall_flag        (req_tdata[12]),
      .start_cell       (req_tdata[24:13]),
      .end_cell         (req_tdata[36:25]),
      .rsp_ready        (rsp_tready),
      .rsp_valid        (rsp_tvalid),
      .rsp_visible      (visible)
   );

   assign rsp_tdata = {7'b0, visible};

endmodule

@@ test/grid_line_of_sight_unit_checker.sv @@
// Checker for the grid line-of-sight unit: mirrors the wall map, predicts and compares results.
module grid_line_of_sight_unit_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [glos_pkg::COLS_CFG_W-1:0] csr_write_data,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [39:0]                     req_tdata,
   input  logic                            req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [7:0]                      rsp_tdata,
   output int                              mismatch_count,
   output int                              lines_pending,
   output int                              lines_checked,
   output int                              lines_blocked
);
   import glos_pkg::*;

   typedef struct packed {
      logic [2:0]        pad;
      logic [CELL_W-1:0] end_cell;
      logic [CELL_W-1:0] start_cell;
      logic              wall_flag;
      logic [CELL_W-1:0] write_cell;
   } line_request_type;

   bit                  wall_map [0:GRID_CELLS_DEF-1];
   logic [COLS_CFG_W-1:0] grid_columns;
   bit                  expected_visible [$];
   line_request_type    accepted;
   bit                  oldest_visible;

   initial begin
      mismatch_count = 0;
      lines_pending  = 0;
      lines_checked  = 0;
      lines_blocked  = 0;
   end

   task automatic report(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // Walk the line point by point, each coordinate rounded half up.
   function automatic bit sight_clear(input int unsigned from_cell, input int unsigned to_cell);
      int unsigned cols, x1, y1, x2, y2, dx, dy, span, idx, px, py, visit_cell;
      if (from_cell == to_cell)
         return 1'b1;
      cols = (grid_columns == 0) ? 1 :
             (grid_columns > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : grid_columns;
      x1 = from_cell % cols;
      y1 = from_cell / cols;
      x2 = to_cell % cols;
      y2 = to_cell / cols;
      dx = (x1 > x2) ? x1 - x2 : x2 - x1;
      dy = (y1 > y2) ? y1 - y2 : y2 - y1;
      span = (dy > dx) ? dy : dx;
      if (span == 0)
         return 1'b1;
      for (idx = 0; idx <= span; idx++) begin
         px = (2 * (x1 * (span - idx) + x2 * idx) + span) / (2 * span);
         py = (2 * (y1 * (span - idx) + y2 * idx) + span) / (2 * span);
         visit_cell = py * cols + px;
         if (visit_cell != from_cell && visit_cell != to_cell &&
             visit_cell < GRID_CELLS_DEF && wall_map[visit_cell])
            return 1'b0;
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (wall_map[k])
            wall_map[k] = 1'b0;
         grid_columns = COLS_RESET;
         expected_visible.delete();
      end else begin
         if (csr_write_enable)
            grid_columns = csr_write_data;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_visible.size() == 0) begin
               report($sformatf("result visible=%0b with no query outstanding", rsp_tdata[0]));
            end else begin
               oldest_visible = expected_visible.pop_front();
               lines_checked++;
               if (!oldest_visible)
                  lines_blocked++;
               if (rsp_tdata[0] !== oldest_visible)
                  report($sformatf("visible got %b expected %0b", rsp_tdata[0], oldest_visible));
            end
         end
         if (req_tvalid && req_tready) begin
            accepted = req_tdata;
            if (req_tuser == OP_WRITE) begin
               if (accepted.write_cell < GRID_CELLS_DEF)
                  wall_map[accepted.write_cell] = accepted.wall_flag;
            end else begin
               expected_visible.push_back(sight_clear(accepted.start_cell, accepted.end_cell));
            end
         end
      end
      lines_pending = expected_visible.size();
   end

endmodule

@@ test/grid_line_of_sight_unit_tb.sv @@
// Testbench top for the grid line-of-sight unit: clock, reset, stimulus and verdict.
module grid_line_of_sight_unit_tb;
   import glos_pkg::*;

   localparam int WINDOW = 192;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [COLS_CFG_W-1:0] csr_write_data;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [39:0]           req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [7:0]            rsp_tdata;

   int mismatch_count, lines_pending, lines_checked, lines_blocked;
   int walls_sent     = 0;
   int queries_sent   = 0;
   int settings_used  = 0;
   bit send_eager     = 1'b0;
   bit rsp_eager      = 1'b0;
   int unsigned rsp_hold    = 0;
   int unsigned rsp_stretch = 0;
   int unsigned rsp_roll;

   logic [COLS_CFG_W-1:0] phase_columns [14] =
      '{7'd37, 7'd1, 7'd127, 7'd8, 7'd65, 7'd0, 7'd2, 7'd64, 7'd13, 7'd50, 7'd3, 7'd21,
        7'd0, 7'd0};

   grid_line_of_sight_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata)
   );

   grid_line_of_sight_unit_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .mismatch_count   (mismatch_count),
      .lines_pending    (lines_pending),
      .lines_checked    (lines_checked),
      .lines_blocked    (lines_blocked)
   );

   always #10 clock = ~clock;

   // Result side: random stalls, mostly short, with eager stretches in between.
   always @(posedge clock) begin
      if (rsp_stretch == 0) begin
         rsp_eager   = ($urandom_range(0, 3) == 0);
         rsp_stretch = $urandom_range(100, 600);
      end else begin
         rsp_stretch--;
      end
      if (rsp_hold != 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else if (rsp_eager) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_roll = $urandom_range(0, 99);
         if (rsp_roll < 60) begin
            rsp_tready <= 1'b1;
         end else if (rsp_roll < 93) begin
            rsp_tready <= 1'b0;
            rsp_hold = $urandom_range(0, 2);
         end else begin
            rsp_tready <= 1'b0;
            rsp_hold = $urandom_range(10, 40);
         end
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (send_eager)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic int unsigned effective_columns(input logic [COLS_CFG_W-1:0] value);
      if (value == 0)
         return 1;
      if (value > MAX_COLUMNS_DEF)
         return MAX_COLUMNS_DEF;
      return 32'(value);
   endfunction

   // Hold the transaction until accepted, then optionally drop valid for a gap.
   task automatic send_item(input logic op, input logic [39:0] payload);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= payload;
      do @(posedge clock); while (req_tready !== 1'b1);
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_wall(input logic [CELL_W-1:0] wall_cell, input logic flag);
      walls_sent++;
      send_item(OP_WRITE, {3'b000, 12'($urandom), 12'($urandom), flag, wall_cell});
   endtask

   task automatic send_query(input logic [CELL_W-1:0] from_cell,
                             input logic [CELL_W-1:0] to_cell);
      queries_sent++;
      send_item(OP_QUERY, {3'b000, to_cell, from_cell, 1'($urandom), 12'($urandom)});
   endtask

   // Write the column count only once the unit has drained.
   task automatic set_columns(input logic [COLS_CFG_W-1:0] value);
      req_tvalid <= 1'b0;
      do @(negedge clock); while (lines_pending != 0);
      repeat (8) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [CELL_W-1:0] near_cell(input int unsigned from_cell,
                                                   input int unsigned cols,
                                                   input int reach);
      int target;
      target = int'(from_cell) + $urandom_range(0, 2 * reach) * int'(cols) - reach * int'(cols)
               + int'($urandom_range(0, 2 * reach)) - reach;
      if (target < 0)
         target = 0;
      if (target > GRID_CELLS_DEF - 1)
         target = GRID_CELLS_DEF - 1;
      return CELL_W'(target);
   endfunction

   // Mostly wall writes and short queries inside a window, plus some long noise lines.
   task automatic random_item(input int unsigned cols, input int unsigned base);
      int unsigned roll;
      int unsigned from_cell;
      roll = $urandom_range(0, 99);
      from_cell = (base + $urandom_range(0, WINDOW - 1)) % GRID_CELLS_DEF;
      if (roll < 35) begin
         if ($urandom_range(0, 9) == 0)
            from_cell = $urandom_range(0, GRID_CELLS_DEF - 1);
         send_wall(CELL_W'(from_cell), ($urandom_range(0, 9) < 7));
      end else if (roll < 40) begin
         send_query(CELL_W'(from_cell), CELL_W'(from_cell));
      end else if (roll < 95) begin
         if ($urandom_range(0, 9) == 0)
            send_query(CELL_W'(from_cell),
                       CELL_W'((base + $urandom_range(0, WINDOW - 1)) % GRID_CELLS_DEF));
         else
            send_query(CELL_W'(from_cell), near_cell(from_cell, cols, 6));
      end else begin
         from_cell = $urandom_range(0, GRID_CELLS_DEF - 1);
         if (cols >= 8)
            send_query(CELL_W'(from_cell), CELL_W'($urandom_range(0, GRID_CELLS_DEF - 1)));
         else
            send_query(CELL_W'(from_cell), near_cell(from_cell, 1, 300));
      end
   endtask

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      req_tuser        = OP_WRITE;
      rsp_tready       = 1'b0;
      phase_columns[12] = $urandom_range(1, 64);
      phase_columns[13] = $urandom_range(0, 127);
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: corner cells, the main diagonal, equal endpoints and a half-way tie.
      send_wall(12'd0, 1'b1);
      send_wall(12'd4095, 1'b1);
      send_query(12'd0, 12'd4095);
      send_wall(12'd65, 1'b1);
      send_query(12'd0, 12'd4095);
      send_query(12'd4095, 12'd0);
      send_query(12'd65, 12'd65);
      send_query(12'd4095, 12'd4095);
      send_query(12'd0, 12'd66);
      send_query(12'd66, 12'd0);
      send_wall(12'd65, 1'b0);
      send_wall(12'd1, 1'b1);
      send_query(12'd0, 12'd66);
      send_query(12'd0, 12'd4095);
      send_query(12'd63, 12'd4032);
      set_columns(7'd0);
      send_query(12'd0, 12'd4095);
      send_wall(12'd2000, 1'b1);
      send_query(12'd0, 12'd4095);
      send_query(12'd4095, 12'd1999);
      send_query(12'd4095, 12'd2001);
      set_columns(7'd127);
      send_query(12'd0, 12'd4095);
      send_wall(12'd4095, 1'b0);
      send_wall(12'd0, 1'b0);

      foreach (phase_columns[p]) begin
         int unsigned base;
         set_columns(phase_columns[p]);
         base = $urandom_range(0, GRID_CELLS_DEF - WINDOW);
         for (int n = 0; n < 61; n++) begin
            if (n % 20 == 0)
               send_eager = ($urandom_range(0, 3) == 0);
            random_item(effective_columns(phase_columns[p]), base);
         end
      end

      req_tvalid <= 1'b0;
      do @(negedge clock); while (lines_pending != 0);
      repeat (40) @(posedge clock);
      $display("covered %0d wall writes and %0d line queries over %0d column settings",
               walls_sent, queries_sent, settings_used);
      $display("%0d lines checked, %0d of them blocked", lines_checked, lines_blocked);
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #100000000;
      $display("timeout with %0d results outstanding", lines_pending);
      $display("TEST FAILED");
      $finish;
   end

endmodule

@@ files.f @@
rtl/glos_pkg.sv
rtl/glos_ram.sv
rtl/glos_ctrl.sv
rtl/glos_dp.sv
rtl/grid_line_of_sight_unit.sv
test/grid_line_of_sight_unit_checker.sv
test/grid_line_of_sight_unit_tb.sv
